[rtl/sacf_pkg.sv]
// Package for the set-associative cache tag store with FIFO replacement.
// Holds sizes, register indexes, the lookup result struct and field helpers.
// No dependencies.
package sacf_pkg;

    localparam int LINES          = 64;
    localparam int MAX_WAYS       = 8;
    localparam int ROWS           = LINES / MAX_WAYS;
    localparam int LINE_W         = $clog2(LINES);
    localparam int BANK_W         = $clog2(MAX_WAYS);
    localparam int ROW_W          = $clog2(ROWS);
    localparam int WAY_W          = 3;
    localparam int WAYS_W         = 4;
    localparam int SET_W          = 6;
    localparam int OFF_W          = 6;
    localparam int TAG_W          = 32;
    localparam int ADDR_W         = 32;
    localparam int FBITS_W        = 3;
    localparam int PTR_DEPTH      = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int M_TDATA_W      = 48;

    localparam logic [FBITS_W-1:0] MAX_FIELD_BITS = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } match_t;

    function automatic logic [FBITS_W-1:0] sat_bits(input logic [FBITS_W-1:0] v);
        return (v > MAX_FIELD_BITS) ? MAX_FIELD_BITS : v;
    endfunction

    function automatic logic [WAYS_W-1:0] eff_ways(input logic [WAYS_W-1:0] v);
        logic [WAYS_W-1:0] w;
        w = v;
        if (w == '0) w = WAYS_W'(1);
        if (w > WAYS_W'(MAX_WAYS)) w = WAYS_W'(MAX_WAYS);
        return w;
    endfunction

endpackage

[rtl/sacf_ram.sv]
// Generic simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module sacf_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/sacf_match.sv]
// Way compare for one set: maps the banked tag reads back to way order
// and picks the lowest valid matching way. Depends on sacf_pkg.
module sacf_match (
    input  logic [sacf_pkg::MAX_WAYS-1:0][sacf_pkg::TAG_W-1:0] bank_tag,
    input  logic [sacf_pkg::LINES-1:0]                         line_valid,
    input  logic [sacf_pkg::LINE_W-1:0]                        base_line,
    input  logic [sacf_pkg::WAYS_W-1:0]                        ways,
    input  logic [sacf_pkg::TAG_W-1:0]                         tag,
    output sacf_pkg::match_t                                   result
);
    import sacf_pkg::*;

    logic [MAX_WAYS-1:0] way_hit;

    always_comb begin
        logic [LINE_W-1:0] ln;
        for (int k = 0; k < MAX_WAYS; k++) begin
            ln = base_line + LINE_W'(k);
            way_hit[k] = (WAYS_W'(k) < ways) && line_valid[ln]
                         && (bank_tag[ln[BANK_W-1:0]] == tag);
        end
    end

    always_comb begin
        result.hit = |way_hit;
        result.way = '0;
        for (int k = MAX_WAYS - 1; k >= 0; k--) begin
            if (way_hit[k]) result.way = WAY_W'(k);
        end
    end

endmodule

[rtl/set_assoc_cache_fifo_top.sv]
// Top level of the set-associative cache tag store with FIFO replacement.
// Depends on sacf_pkg, sacf_ram and sacf_match.
// Flow: tags and pointer are read at the accepting edge; the lookup state then
// compares, writes back and registers the result, holding while the output stalls.
// One item at a time, set by the read-modify-write of the tag banks and pointer RAM.
// Reset: line valid bits and pointer-written bits clear at once; no sweep.
module set_assoc_cache_fifo_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sacf_pkg::ADDR_W-1:0]         s_tdata,  // address
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sacf_pkg::M_TDATA_W-1:0]      m_tdata,  // tag_value, set_number,
                                                          // byte_offset, way_used, pad
    output logic                                m_tuser   // hit
);
    import sacf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [FBITS_W-1:0] offset_bits_reg, set_index_bits_reg;
    logic [WAYS_W-1:0]  ways_reg;

    logic [LINES-1:0]     line_valid_reg;
    logic [PTR_DEPTH-1:0] ptr_written_reg;

    logic [TAG_W-1:0]  tag_reg;
    logic [SET_W-1:0]  set_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [LINE_W-1:0] base_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic accept, adv;
    logic [FBITS_W-1:0] ob, ib;
    logic [OFF_W-1:0]   in_off;
    logic [SET_W-1:0]   in_set;
    logic [TAG_W-1:0]   in_tag;
    logic [LINE_W-1:0]  in_base;
    logic [ADDR_W-1:0]  shifted;
    logic [SET_W+WAYS_W-1:0] set_prod;

    logic [MAX_WAYS-1:0][ROW_W-1:0] rd_row;
    logic [MAX_WAYS-1:0][TAG_W-1:0] bank_tag;
    logic [MAX_WAYS-1:0]            bank_we;
    logic [WAY_W-1:0]               ptr_rdata;

    match_t            match;
    logic [WAYS_W-1:0] ptr_cur, ptr_eff, ptr_inc, ptr_new;
    logic [WAY_W-1:0]  fill_way, way_out;
    logic [LINE_W-1:0] fill_line;
    logic              fill;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign adv       = (state_reg == ST_LOOKUP) && (!m_tvalid_reg || m_tready);

    // field split of the incoming address
    always_comb begin
        ob       = sat_bits(offset_bits_reg);
        ib       = sat_bits(set_index_bits_reg);
        in_off   = OFF_W'(s_tdata & ((ADDR_W'(1) << ob) - ADDR_W'(1)));
        shifted  = s_tdata >> ob;
        in_set   = SET_W'(shifted & ((ADDR_W'(1) << ib) - ADDR_W'(1)));
        in_tag   = s_tdata >> ({1'b0, ob} + {1'b0, ib});
        set_prod = {{WAYS_W{1'b0}}, in_set} * {{SET_W{1'b0}}, ways_reg};
        in_base  = set_prod[LINE_W-1:0];
    end

    // each bank holds at most one line of the set's window
    always_comb begin
        logic [BANK_W-1:0] k;
        logic [LINE_W-1:0] ln;
        for (int b = 0; b < MAX_WAYS; b++) begin
            k         = BANK_W'(b) - in_base[BANK_W-1:0];
            ln        = in_base + LINE_W'(k);
            rd_row[b] = ln[LINE_W-1:BANK_W];
        end
    end

    always_comb begin
        ptr_cur   = ptr_written_reg[set_reg] ? WAYS_W'(ptr_rdata) : '0;
        ptr_eff   = (ptr_cur >= ways_reg) ? '0 : ptr_cur;
        ptr_inc   = ptr_eff + WAYS_W'(1);
        ptr_new   = (ptr_inc >= ways_reg) ? '0 : ptr_inc;
        fill_way  = ptr_eff[WAY_W-1:0];
        fill_line = base_reg + LINE_W'(fill_way);
        fill      = adv && !match.hit;
        way_out   = match.hit ? match.way : fill_way;
        for (int b = 0; b < MAX_WAYS; b++) begin
            bank_we[b] = fill && (fill_line[BANK_W-1:0] == BANK_W'(b));
        end
    end

    for (genvar b = 0; b < MAX_WAYS; b++) begin : g_bank
        sacf_ram #(
            .DEPTH(ROWS),
            .WIDTH(TAG_W)
        ) u_tag_bank (
            .aclk  (aclk),
            .we    (bank_we[b]),
            .waddr (fill_line[LINE_W-1:BANK_W]),
            .wdata (tag_reg),
            .re    (accept),
            .raddr (rd_row[b]),
            .rdata (bank_tag[b])
        );
    end

    sacf_ram #(
        .DEPTH(PTR_DEPTH),
        .WIDTH(WAY_W)
    ) u_ptr_ram (
        .aclk  (aclk),
        .we    (fill),
        .waddr (set_reg),
        .wdata (ptr_new[WAY_W-1:0]),
        .re    (accept),
        .raddr (in_set),
        .rdata (ptr_rdata)
    );

    sacf_match u_match (
        .bank_tag   (bank_tag),
        .line_valid (line_valid_reg),
        .base_line  (base_reg),
        .ways       (ways_reg),
        .tag        (tag_reg),
        .result     (match)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (adv) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            offset_bits_reg    <= 3'd3;
            set_index_bits_reg <= 3'd2;
            ways_reg           <= 4'd4;
            line_valid_reg     <= '0;
            ptr_written_reg    <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_data[FBITS_W-1:0];
                    CFG_SET_INDEX_BITS: set_index_bits_reg <= cfg_data[FBITS_W-1:0];
                    CFG_WAYS_IN_USE:    ways_reg           <= eff_ways(cfg_data);
                    default: ;
                endcase
            end
            if (fill) begin
                line_valid_reg[fill_line] <= 1'b1;
                ptr_written_reg[set_reg]  <= 1'b1;
            end
            if (adv) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tag_reg  <= in_tag;
            set_reg  <= in_set;
            off_reg  <= in_off;
            base_reg <= in_base;
        end
        if (adv) begin
            m_tdata_reg <= {1'b0, way_out, off_reg, set_reg, tag_reg};
            m_tuser_reg <= match.hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second item taken during lookup");

    a_result_due: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_tvalid)
        else $error("lookup finished without a result");

    a_fill_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fill |=> line_valid_reg[$past(fill_line)])
        else $error("filled line not marked valid");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && match.hit) |-> (WAYS_W'(match.way) < ways_reg))
        else $error("hit reported beyond ways in use");

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill |-> (WAYS_W'(fill_way) < ways_reg))
        else $error("fill way beyond ways in use");

endmodule

[tb/sv/set_assoc_cache_fifo_top_tb.sv]
// Self-checking testbench for set_assoc_cache_fifo_top: streams address items in,
// predicts hit/way per access with its own tag-store model, and checks every result.
// Depends on sacf_pkg and the set_assoc_cache_fifo_top RTL.
module set_assoc_cache_fifo_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sacf_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set_no;
        logic [OFF_W-1:0] offset;
        logic [WAY_W-1:0] way;
    } access_res_t;

    typedef enum logic { STEP_CFG, STEP_ADDR } step_kind_t;

    typedef struct {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [ADDR_W-1:0]    val;
        logic                 chk;
        access_res_t          want;
    } dir_step_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 88;
    localparam int POOL_SIZE    = 12;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ADDR_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    // shadow of the tag store
    logic [TAG_W-1:0]   tag_mem   [LINES];
    logic               valid_mem [LINES];
    int unsigned        fifo_ptr  [PTR_DEPTH];
    logic [FBITS_W-1:0] ob_reg   = 3'd3;
    logic [FBITS_W-1:0] ib_reg   = 3'd2;
    logic [WAYS_W-1:0]  ways_reg = 4'd4;

    access_res_t pending_q [$];
    dir_step_t   dir_steps [$];

    int tx_idle_pct = 33;
    int rx_idle_pct = 77;
    int n_errors    = 0;
    int n_items     = 0;
    int n_hits      = 0;
    int n_cfg       = 0;

    set_assoc_cache_fifo_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic access_res_t cache_lookup(input logic [ADDR_W-1:0] a);
        access_res_t r;
        int unsigned ob, ib, nw, sidx, ln, p, w;
        ob = (ob_reg > 3'd6) ? 6 : ob_reg;
        ib = (ib_reg > 3'd6) ? 6 : ib_reg;
        nw = (ways_reg == '0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
        sidx = (a >> ob) & ((32'd1 << ib) - 32'd1);
        r.hit = 1'b0;
        r.way = '0;
        r.tag = a >> (ob + ib);
        r.set_no = SET_W'(sidx);
        r.offset = OFF_W'(a & ((32'd1 << ob) - 32'd1));
        for (w = 0; w < nw; w++) begin
            ln = (sidx * nw + w) % LINES;
            if (!r.hit && valid_mem[ln] && tag_mem[ln] == r.tag) begin
                r.hit = 1'b1;
                r.way = WAY_W'(w);
            end
        end
        if (!r.hit) begin
            p = fifo_ptr[sidx];
            if (p >= nw) p = 0;   // stale pointer after a ways change
            r.way = WAY_W'(p);
            ln = (sidx * nw + p) % LINES;
            tag_mem[ln] = r.tag;
            valid_mem[ln] = 1'b1;
            fifo_ptr[sidx] = (p + 1 >= nw) ? 0 : p + 1;
        end
        return r;
    endfunction

    function automatic void field_chk(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, fname, want, got);
        end
    endfunction

    function automatic void add_step(input step_kind_t k, input logic [CFG_IDX_W-1:0] idx,
                                     input logic [ADDR_W-1:0] val, input logic chk,
                                     input access_res_t want);
        dir_step_t st;
        st.kind = k;
        st.idx  = idx;
        st.val  = val;
        st.chk  = chk;
        st.want = want;
        dir_steps.push_back(st);
    endfunction

    always @(posedge aclk) begin
        access_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit    = m_tuser;
            got.tag    = m_tdata[31:0];
            got.set_no = m_tdata[37:32];
            got.offset = m_tdata[43:38];
            got.way    = m_tdata[46:44];
            if (pending_q.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected result item, expected none, got %h", $time, got);
            end else begin
                want = pending_q.pop_front();
                field_chk("hit", 32'(want.hit), 32'(got.hit));
                field_chk("tag_value", want.tag, got.tag);
                field_chk("set_number", 32'(want.set_no), 32'(got.set_no));
                field_chk("byte_offset", 32'(want.offset), 32'(got.offset));
                field_chk("way_used", 32'(want.way), 32'(got.way));
                if (got.hit) n_hits++;
            end
        end
    end

    task automatic send_addr(input logic [ADDR_W-1:0] a, input logic chk,
                             input access_res_t want);
        access_res_t r;
        int gap;
        gap = 0;
        while (gap < 6 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = cache_lookup(a);
        pending_q.push_back(chk ? want : r);
        n_items++;
    endtask

    // stop sending and let every outstanding lookup come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OFFSET_BITS:    ob_reg = d[2:0];
            CFG_SET_INDEX_BITS: ib_reg = d[2:0];
            CFG_WAYS_IN_USE:    ways_reg = d;
            default: ;
        endcase
        n_cfg++;
    endtask

    initial begin
        #5ms;
        $display("set_assoc_cache_fifo_top verification failed");
        $finish;
    end

    initial begin
        int p, i, pick, obe, ibe;
        logic [ADDR_W-1:0] a, last_addr, off_mask;
        logic [ADDR_W-1:0] hot_pool [POOL_SIZE];
        logic [CFG_DATA_W-1:0] ph_ob, ph_ib, ph_ways;

        for (i = 0; i < LINES; i++) begin
            tag_mem[i] = '0;
            valid_mem[i] = 1'b0;
        end
        for (i = 0; i < PTR_DEPTH; i++) fifo_ptr[i] = 0;

        // reset config: 8-byte blocks, 4 sets, 4 ways
        add_step(STEP_ADDR, '0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, 6'd0, 3'd0});
        add_step(STEP_ADDR, '0, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 6'd0, 6'd0, 3'd0});
        add_step(STEP_ADDR, '0, 32'hFFFF_FFFF, 1'b1,
                 '{1'b0, 32'h07FF_FFFF, 6'd3, 6'd7, 3'd0});
        add_step(STEP_ADDR, '0, 32'h0000_0020, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0040, 1'b0, '0);
        // set 0 pointer now sits past the new way count
        add_step(STEP_CFG, CFG_WAYS_IN_USE, 32'h2, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0080, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0020, 1'b0, '0);
        add_step(STEP_CFG, CFG_WAYS_IN_USE, 32'h0, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'hAAAA_AAAA, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h5555_5555, 1'b0, '0);
        // saturated field widths, ways clamped to 8, sets wrap onto shared lines
        add_step(STEP_CFG, CFG_OFFSET_BITS, 32'hF, 1'b0, '0);
        add_step(STEP_CFG, CFG_SET_INDEX_BITS, 32'h7, 1'b0, '0);
        add_step(STEP_CFG, CFG_WAYS_IN_USE, 32'hF, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'hFFFF_FFFF, 1'b1,
                 '{1'b0, 32'h000F_FFFF, 6'd63, 6'd63, 3'd0});
        add_step(STEP_ADDR, '0, 32'h0000_0FFF, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'hFFFF_F1C0, 1'b0, '0);
        add_step(STEP_CFG, CFG_SPARE_IDX, 32'h5, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'hFFFF_F1C0, 1'b0, '0);
        // same tag in two lines, then both lines land in one set
        add_step(STEP_CFG, CFG_OFFSET_BITS, 32'h0, 1'b0, '0);
        add_step(STEP_CFG, CFG_SET_INDEX_BITS, 32'h1, 1'b0, '0);
        add_step(STEP_CFG, CFG_WAYS_IN_USE, 32'h1, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0002, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0003, 1'b0, '0);
        add_step(STEP_CFG, CFG_OFFSET_BITS, 32'h1, 1'b0, '0);
        add_step(STEP_CFG, CFG_SET_INDEX_BITS, 32'h0, 1'b0, '0);
        add_step(STEP_CFG, CFG_WAYS_IN_USE, 32'h2, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0002, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0003, 1'b0, '0);
        // single line cache
        add_step(STEP_CFG, CFG_OFFSET_BITS, 32'h0, 1'b0, '0);
        add_step(STEP_CFG, CFG_WAYS_IN_USE, 32'h1, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'hFFFF_FFFF, 1'b1,
                 '{1'b0, 32'hFFFF_FFFF, 6'd0, 6'd0, 3'd0});
        add_step(STEP_ADDR, '0, 32'h0000_0000, 1'b0, '0);
        add_step(STEP_ADDR, '0, 32'h0000_0000, 1'b0, '0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_steps[k]) begin
            if (dir_steps[k].kind == STEP_CFG)
                write_reg(dir_steps[k].idx, CFG_DATA_W'(dir_steps[k].val));
            else
                send_addr(dir_steps[k].val, dir_steps[k].chk, dir_steps[k].want);
        end

        last_addr = '0;
        for (p = 0; p < PHASES; p++) begin
            case (p * 3 / PHASES)
                0: begin
                    tx_idle_pct = 33;
                    rx_idle_pct = 77;
                end
                1: begin
                    tx_idle_pct = 77;
                    rx_idle_pct = 33;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (p)
                0: {ph_ob, ph_ib, ph_ways} = {4'h3, 4'h2, 4'h4};
                1: {ph_ob, ph_ib, ph_ways} = {4'h0, 4'h0, 4'h8};
                2: {ph_ob, ph_ib, ph_ways} = {4'h6, 4'h6, 4'h1};
                3: {ph_ob, ph_ib, ph_ways} = {4'hF, 4'h7, 4'hF};
                4: {ph_ob, ph_ib, ph_ways} = {4'h2, 4'h3, 4'h0};
                5: {ph_ob, ph_ib, ph_ways} = {4'h1, 4'h4, 4'h5};
                8: {ph_ob, ph_ib, ph_ways} = {4'h4, 4'h5, 4'h3};
                default: begin
                    ph_ob   = CFG_DATA_W'($urandom_range(0, 15));
                    ph_ib   = CFG_DATA_W'($urandom_range(0, 15));
                    ph_ways = CFG_DATA_W'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_OFFSET_BITS, ph_ob);
            write_reg(CFG_SET_INDEX_BITS, ph_ib);
            write_reg(CFG_WAYS_IN_USE, ph_ways);

            obe = (ob_reg > 3'd6) ? 6 : ob_reg;
            ibe = (ib_reg > 3'd6) ? 6 : ib_reg;
            off_mask = (32'd1 << obe) - 32'd1;
            // hot blocks crowd a few sets so replacement gets exercised
            for (i = 0; i < POOL_SIZE; i++)
                hot_pool[i] = ($urandom << (obe + ibe)) | (32'($urandom_range(0, 3)) << obe);

            for (i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    hot_pool[$urandom_range(0, POOL_SIZE - 1)] =
                        ($urandom << (obe + ibe)) | (32'($urandom_range(0, 3)) << obe);
                if (pick < 70)
                    a = hot_pool[$urandom_range(0, POOL_SIZE - 1)] | ($urandom & off_mask);
                else if (pick < 85)
                    a = last_addr;
                else
                    a = $urandom;
                if (p == 4 && i == PHASE_ITEMS / 2) settle();
                send_addr(a, 1'b0, '0);
                last_addr = a;
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        $display("Ran %0d lookups (%0d hits, %0d misses) over %0d register writes,",
                 n_items, n_hits, n_items - n_hits, n_cfg);
        $display("directed corner cases plus %0d random phases with mixed back-pressure.",
                 PHASES);
        if (n_errors == 0) begin
            $display("set_assoc_cache_fifo_top verification clean");
        end else begin
            $display("set_assoc_cache_fifo_top verification failed");
        end
        $finish;
    end

endmodule
